[design/sbda_pkg.sv]
// shared constants and types for the signed binary to decimal ascii converter
package sbda_pkg;

  localparam int BinWidth   = 32;
  localparam int DigitCount = 10;
  localparam int BcdWidth   = 4 * DigitCount;
  localparam int CntWidth   = $clog2(BinWidth + 1);
  localparam int IdxWidth   = $clog2(DigitCount + 1);

  localparam logic [7:0] AsciiZero  = 8'h30;
  localparam logic [7:0] AsciiMinus = 8'h2D;

  // handoff from the conversion unit to the character emitter
  typedef struct packed {
    logic                neg;
    logic [BcdWidth-1:0] bcd;
  } sbda_load_t;

endpackage

[design/sbda_dabble.sv]
// bit-serial shift-and-add-3 binary to bcd conversion unit
module sbda_dabble (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          load,
  input  logic [sbda_pkg::BinWidth-1:0] mag,
  output logic                          done,
  output logic [sbda_pkg::BcdWidth-1:0] bcd
);
  import sbda_pkg::*;

  logic [BinWidth-1:0] bin_r, bin_nxt;
  logic [BcdWidth-1:0] bcd_r, bcd_nxt, adj;
  logic [CntWidth-1:0] cnt_r, cnt_nxt;
  logic                run_r, run_nxt;
  logic                done_r, done_nxt;

  // add 3 to every digit of five or more, then shift in one binary bit
  always_comb begin
    for (int i = 0; i < DigitCount; i++) begin
      if (bcd_r[4*i +: 4] >= 4'd5) begin
        adj[4*i +: 4] = bcd_r[4*i +: 4] + 4'd3;
      end else begin
        adj[4*i +: 4] = bcd_r[4*i +: 4];
      end
    end
  end

  always_comb begin
    bin_nxt  = bin_r;
    bcd_nxt  = bcd_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    if (load) begin
      bin_nxt = mag;
      bcd_nxt = '0;
      cnt_nxt = CntWidth'(BinWidth);
      run_nxt = 1'b1;
    end else if (run_r) begin
      bin_nxt = {bin_r[BinWidth-2:0], 1'b0};
      bcd_nxt = {adj[BcdWidth-2:0], bin_r[BinWidth-1]};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CntWidth'(1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bin_r <= bin_nxt;
    bcd_r <= bcd_nxt;
  end

  assign done = done_r;
  assign bcd  = bcd_r;

endmodule

[design/sbda_emit.sv]
// character emitter: sign, leading zero skip, then one digit per cycle
module sbda_emit (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 load,
  input  sbda_pkg::sbda_load_t load_data,
  output logic                 out_strobe,
  output logic [7:0]           out_char,
  output logic                 out_last
);
  import sbda_pkg::*;

  logic [BcdWidth-1:0] dig_r, dig_nxt;
  logic [IdxWidth-1:0] idx_r, idx_nxt;
  logic                sign_r, sign_nxt;
  logic                seen_r, seen_nxt;
  logic                run_r, run_nxt;
  logic                strobe_r, strobe_nxt;
  logic [7:0]          char_r, char_nxt;
  logic                last_r, last_nxt;
  logic [3:0]          top;
  logic                final_dig;

  assign top       = dig_r[BcdWidth-1 -: 4];
  assign final_dig = (idx_r == IdxWidth'(1));

  always_comb begin
    dig_nxt    = dig_r;
    idx_nxt    = idx_r;
    sign_nxt   = sign_r;
    seen_nxt   = seen_r;
    run_nxt    = run_r;
    strobe_nxt = 1'b0;
    char_nxt   = char_r;
    last_nxt   = 1'b0;
    if (load) begin
      dig_nxt  = load_data.bcd;
      idx_nxt  = IdxWidth'(DigitCount);
      sign_nxt = load_data.neg;
      seen_nxt = 1'b0;
      run_nxt  = 1'b1;
    end else if (run_r) begin
      if (sign_r) begin
        strobe_nxt = 1'b1;
        char_nxt   = AsciiMinus;
        sign_nxt   = 1'b0;
      end else begin
        // leading zeros are dropped, but the units digit always goes out
        if (top != 4'd0 || seen_r || final_dig) begin
          strobe_nxt = 1'b1;
          char_nxt   = AsciiZero + {4'b0000, top};
          last_nxt   = final_dig;
          seen_nxt   = 1'b1;
        end
        dig_nxt = {dig_r[BcdWidth-5:0], 4'b0000};
        idx_nxt = idx_r - 1'b1;
        if (final_dig) begin
          run_nxt = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r    <= 1'b0;
      strobe_r <= 1'b0;
      last_r   <= 1'b0;
      sign_r   <= 1'b0;
      seen_r   <= 1'b0;
      idx_r    <= '0;
    end else begin
      run_r    <= run_nxt;
      strobe_r <= strobe_nxt;
      last_r   <= last_nxt;
      sign_r   <= sign_nxt;
      seen_r   <= seen_nxt;
      idx_r    <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dig_r  <= dig_nxt;
    char_r <= char_nxt;
  end

  assign out_strobe = strobe_r;
  assign out_char   = char_r;
  assign out_last   = last_r;

endmodule

[design/signed_binary_to_decimal_ascii.sv]
// top level: signed 32-bit integer to decimal ascii text, one character per strobe
//
// A transaction is accepted on the clock edge where start is high and busy is low.
// The value's magnitude (the most negative value included) runs through a bit-serial
// shift-and-add-3 converter, then the emitter walks the ten bcd digits
// one per cycle, sending '-' first for negative inputs and dropping leading zeros.
// Each character appears on out_char for exactly one cycle with out_strobe high; the
// receiver cannot stall, so it must take every strobed character. out_last marks the
// final character. busy stays high from acceptance until the cycle after the last
// character; the span does not depend on the digit count, as it covers the conversion,
// a handoff to the emitter, a slot for every bcd digit, the final character on the
// output register, and a further slot for the sign when the value is negative.
module signed_binary_to_decimal_ascii (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic signed [31:0] in_value,
  output logic        out_strobe,
  output logic [7:0]  out_char,
  output logic        out_last
);
  import sbda_pkg::*;

  // sequencer codes
  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StConv = 2'd1;
  localparam logic [1:0] StEmit = 2'd2;

  logic [1:0]          state_r, state_nxt;
  logic                neg_r, neg_nxt;
  logic                accept;
  logic [BinWidth-1:0] mag;
  logic                dab_done;
  logic [BcdWidth-1:0] dab_bcd;
  sbda_load_t          emit_load;

  assign accept = start && (state_r == StIdle);

  // two's complement negate; 0x80000000 maps to itself, which is the right magnitude
  assign mag = in_value[31] ? (~in_value + 32'd1) : in_value;

  always_comb begin
    state_nxt = state_r;
    neg_nxt   = neg_r;
    unique case (state_r)
      StIdle: begin
        if (accept) begin
          state_nxt = StConv;
          neg_nxt   = in_value[31];
        end
      end
      StConv: begin
        if (dab_done) begin
          state_nxt = StEmit;
        end
      end
      StEmit: begin
        // last character is on the ports now, free next cycle
        if (out_strobe && out_last) begin
          state_nxt = StIdle;
        end
      end
      default: begin
        state_nxt = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= StIdle;
      neg_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      neg_r   <= neg_nxt;
    end
  end

  assign busy = (state_r != StIdle);

  sbda_dabble u_dabble (
    .clk   (clk),
    .rst_n (rst_n),
    .load  (accept),
    .mag   (mag),
    .done  (dab_done),
    .bcd   (dab_bcd)
  );

  assign emit_load.neg = neg_r;
  assign emit_load.bcd = dab_bcd;

  sbda_emit u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (dab_done),
    .load_data  (emit_load),
    .out_strobe (out_strobe),
    .out_char   (out_char),
    .out_last   (out_last)
  );

endmodule

[design/sbda_checker.sv]
// port-level checker for the converter and its bind
module sbda_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic       out_strobe,
  input logic [7:0] out_char,
  input logic       out_last
);
  import sbda_pkg::*;

  // an accepted transaction makes the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("busy not raised after accepted transaction");

  // characters only come out while a transaction is in flight
  a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> busy)
    else $error("character strobed while idle");

  // only minus (never last) or a decimal digit
  a_char_set: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (out_char == AsciiMinus && !out_last) ||
                   (out_char >= AsciiZero && out_char <= (AsciiZero + 8'd9)))
    else $error("illegal character");

  // busy drops right after the final character
  a_busy_fall: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> $past(out_strobe && out_last))
    else $error("busy fell without a final character");

  a_last_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_last |=> !out_strobe)
    else $error("character right after the final one");

endmodule

bind signed_binary_to_decimal_ascii sbda_checker u_sbda_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .out_strobe (out_strobe),
  .out_char   (out_char),
  .out_last   (out_last)
);

[test/signed_binary_to_decimal_ascii_tb.sv]
// testbench for the signed binary to decimal ascii converter: directed, random and burst values
module signed_binary_to_decimal_ascii_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sbda_pkg::*;

  localparam int          ClkHalf     = 5;
  localparam int          ResetCycles = 4;
  localparam int          DecimalBase = 10;
  localparam int          IdlePercent = 33;
  localparam int          MaxGap      = 60;
  localparam int          DrainLimit  = 2000;
  localparam int          TailCycles  = 60;
  localparam logic [31:0] MostNeg     = 32'h8000_0000;
  localparam logic [31:0] MostPos     = 32'h7FFF_FFFF;

  // one character of the expected decimal text
  typedef struct {
    logic [7:0] ch;
    logic       last;
  } text_char_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic signed [31:0] in_value = '0;
  logic               out_strobe;
  logic [7:0]         out_char;
  logic               out_last;

  text_char_t  pending_text[$];   // characters still owed by the converter
  int          error_count = 0;
  bit          idle_en = 1'b0;    // random gaps before a transaction when set

  signed_binary_to_decimal_ascii u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_value  (in_value),
    .out_strobe(out_strobe),
    .out_char  (out_char),
    .out_last  (out_last)
  );

  always #ClkHalf clk = ~clk;

  // expected text for one value: optional '-' then digits, last flag on the final digit
  function automatic void predict_text(logic signed [31:0] v);
    logic [32:0] mag;
    logic [3:0]  digits[DigitCount];
    int          nd;
    text_char_t  c;
    // 33-bit magnitude so the most negative value has a positive form
    mag = v[31] ? (33'd0 - {v[31], v}) : {1'b0, v};
    nd  = 0;
    if (mag == 0) begin
      digits[0] = 4'd0;
      nd = 1;
    end
    while (mag != 0) begin
      digits[nd] = 4'(mag % DecimalBase);
      mag = mag / DecimalBase;
      nd++;
    end
    if (v[31]) begin
      c.ch   = AsciiMinus;
      c.last = 1'b0;
      pending_text.push_back(c);
    end
    for (int k = nd - 1; k >= 0; k--) begin
      c.ch   = AsciiZero + 8'(digits[k]);
      c.last = (k == 0);
      pending_text.push_back(c);
    end
  endfunction

  // drive one transaction at the falling edge, hold it until the block takes it
  task automatic send_value(logic signed [31:0] v);
    @(negedge clk);
    if (idle_en && $urandom_range(99) < IdlePercent) begin
      start <= 1'b0;
      // gap length spans the whole conversion so start lands on every phase
      repeat ($urandom_range(1, MaxGap)) @(negedge clk);
    end
    start    <= 1'b1;
    in_value <= v;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    // accepted on this edge
    predict_text(v);
  endtask

  // random value biased toward the interesting places of decimal text
  function automatic logic signed [31:0] pick_value();
    logic signed [31:0] p;
    logic signed [31:0] v;
    p = 1;
    case ($urandom_range(3))
      0: v = $urandom;
      1: v = $urandom_range(999);
      2: begin
        // powers of ten and their neighbors, where the digit count changes
        repeat ($urandom_range(DigitCount - 1)) p = p * DecimalBase;
        v = p + $signed($urandom_range(2)) - 1;
      end
      default: begin
        // close to the extremes of the field
        v = $urandom_range(1) ? MostPos - $urandom_range(20) : MostNeg + $urandom_range(20);
      end
    endcase
    // flip the sign half the time, the most negative value stays as it is
    if (v != MostNeg && $urandom_range(1)) v = -v;
    return v;
  endfunction

  // extremes, zero, single digits, digit count boundaries, alternating bit patterns
  task automatic test_boundary_values();
    logic signed [31:0] vals[$];
    vals = '{0, 1, -1, 9, -9, 10, -10, 100, MostPos, MostNeg, MostNeg + 1, 999999999,
             1000000000, -999999999, -1000000000, 12345, -12345, 32'h5555_5555,
             32'hAAAA_AAAA, 32'h0000_FFFF, 32'hFFFF_0000};
    idle_en = 1'b0;
    foreach (vals[i]) send_value(vals[i]);
  endtask

  // random values with random gaps between transactions
  task automatic test_random_values(int count);
    idle_en = 1'b1;
    repeat (count) send_value(pick_value());
  endtask

  // long stretch with start held high, each transaction right after busy drops
  task automatic test_back_to_back(int count);
    idle_en = 1'b0;
    repeat (count) send_value(pick_value());
  endtask

  // every strobed character is compared against the oldest owed character
  always @(posedge clk) begin
    text_char_t e;
    if (rst_n && out_strobe) begin
      if (pending_text.size() == 0) begin
        $display("%0t: unexpected character: char 0x%02h last %0b", $time, out_char, out_last);
        error_count++;
      end else begin
        e = pending_text.pop_front();
        if (out_char !== e.ch) begin
          $display("%0t: out_char mismatch: expected 0x%02h actual 0x%02h",
                   $time, e.ch, out_char);
          error_count++;
        end
        if (out_last !== e.last) begin
          $display("%0t: out_last mismatch: expected %0b actual %0b",
                   $time, e.last, out_last);
          error_count++;
        end
      end
    end
  end

  initial begin
    int waited;
    repeat (ResetCycles) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_boundary_values();
    test_random_values(200);
    test_back_to_back(60);

    @(negedge clk);
    start <= 1'b0;
    // let the last text drain, then watch for stray characters
    waited = 0;
    while (pending_text.size() != 0 && waited < DrainLimit) begin
      @(posedge clk);
      waited++;
    end
    if (pending_text.size() != 0) begin
      $display("%0t: %0d characters never arrived", $time, pending_text.size());
      error_count++;
    end
    repeat (TailCycles) @(posedge clk);

    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // watchdog, far beyond the slowest correct run
  initial begin
    #2_000_000;
    $display("%0t: timeout", $time);
    $display("DONE: errors detected");
    $finish;
  end

endmodule
